// File: rtl/rpn_pkg.sv
// rpn evaluator shared types, constants and codes
package rpn_pkg;

	localparam int unsigned StackDepth = 128;
	localparam int unsigned SpW        = $clog2(StackDepth + 1);
	localparam int unsigned AddrW      = $clog2(StackDepth);
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [2:0] {
		ACT_PUSH  = 3'd0,
		ACT_ADD   = 3'd1,
		ACT_SUB   = 3'd2,
		ACT_MUL   = 3'd3,
		ACT_DIV   = 3'd4,
		ACT_PRINT = 3'd5,
		ACT_UNK   = 3'd6,
		ACT_RSVD  = 3'd7
	} action_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] number_value;
	} in_item_t;

	typedef struct packed {
		logic               print_valid;
		logic signed [31:0] printed_value;
		logic               stack_underflow;
		logic               stack_overflow;
		logic               divide_by_zero;
		logic               unknown_command;
		logic               arith_saturated;
		logic [7:0]         stack_depth;
	} out_item_t;

	// classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_PUSH  = 3'd0,
		OP_ADD   = 3'd1,
		OP_SUB   = 3'd2,
		OP_MUL   = 3'd3,
		OP_DIV   = 3'd4,
		OP_PRINT = 3'd5,
		OP_NONE  = 3'd6
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] operand;
	} cmd_t;

	localparam logic signed [31:0] QMax = 32'sh7fffffff;
	localparam logic signed [31:0] QMin = 32'sh80000000;

endpackage

// File: rtl/rpn_front.sv
// front end: accepts tokens, classifies them and queues commands
module rpn_front import rpn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	output logic     cmd_valid,
	input  logic     cmd_take,
	output cmd_t     cmd
);
	localparam int unsigned PtrW = $clog2(QueueDepth);

	cmd_t            queue_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0]   count_q;
	logic            push, pop;
	cmd_t            cls;

	always_comb begin
		cls.operand = in_item.number_value;
		unique case (action_t'(in_item.action))
			ACT_PUSH:  cls.op = OP_PUSH;
			ACT_ADD:   cls.op = OP_ADD;
			ACT_SUB:   cls.op = OP_SUB;
			ACT_MUL:   cls.op = OP_MUL;
			ACT_DIV:   cls.op = OP_DIV;
			ACT_PRINT: cls.op = OP_PRINT;
			default:   cls.op = OP_NONE;
		endcase
	end

	assign in_stall  = (count_q == (PtrW+1)'(QueueDepth));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = queue_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			count_q <= count_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) queue_q[wr_q] <= cls;
	end
endmodule

// File: rtl/rpn_div.sv
// sequential restoring divider for q16.16 quotients
module rpn_div import rpn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] dividend,
	input  logic signed [31:0] divisor,
	output logic               done,
	output logic signed [31:0] quotient,
	output logic               saturated
);
	// |dividend| * 65536 is at most 2^47, so 48 quotient bits
	logic [47:0] num_q, quo_q;
	logic [31:0] den_q;
	logic [32:0] rem_q;
	logic        neg_q, busy_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;
	logic [33:0] diff;
	logic [48:0] sq;

	assign trial = {rem_q[31:0], num_q[47]};
	assign diff  = {1'b0, trial} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {(dividend[31] ? 32'(-dividend) : 32'(dividend)), 16'd0};
			den_q <= divisor[31] ? 32'(-divisor) : 32'(divisor);
			neg_q <= dividend[31] ^ divisor[31];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[46:0], 1'b0};
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	always_comb begin
		sq = neg_q ? 49'(-{1'b0, quo_q}) : {1'b0, quo_q};
		saturated = 1'b0;
		quotient  = sq[31:0];
		if (!neg_q && quo_q > 48'h7fffffff) begin
			saturated = 1'b1;
			quotient  = QMax;
		end else if (neg_q && quo_q > 48'h80000000) begin
			saturated = 1'b1;
			quotient  = QMin;
		end
	end
endmodule

// File: rtl/rpn_back.sv
// back end: operand stack, arithmetic and result register
module rpn_back import rpn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_take,
	input  cmd_t      cmd,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_RDB  = 8'b0000_0010,
		ST_RDA  = 8'b0000_0100,
		ST_WAIT = 8'b0000_1000,
		ST_EXEC = 8'b0001_0000,
		ST_MUL  = 8'b0010_0000,
		ST_DIVW = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [31:0]        mem [StackDepth];
	logic [31:0]        rd_data_q;
	logic               rd_ok_q;
	logic [SpW-1:0]     sp_q;
	cmd_t               cur_q;
	logic signed [31:0] a_q, b_q, res_q;
	logic               under_q, over_q, sat_q, dz_q, pv_q, push_q;
	logic signed [63:0] prod_q;
	logic               rd_en;
	logic [AddrW-1:0]   rd_addr;
	logic               div_start, div_done, div_sat;
	logic signed [31:0] div_quo;
	logic signed [32:0] sum;
	logic signed [47:0] fl;

	rpn_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(a_q), .divisor(b_q), .done(div_done),
		.quotient(div_quo), .saturated(div_sat)
	);

	assign cmd_take = (state_q == ST_IDLE) && cmd_valid && !out_valid;
	assign rd_en    = (state_q == ST_RDB || state_q == ST_RDA) && sp_q != '0;
	assign rd_addr  = AddrW'(sp_q - 1'b1);
	// operands are settled once the second read has landed in a_q
	assign div_start = (state_q == ST_MUL) && (cur_q.op == OP_DIV);
	assign sum = (cur_q.op == OP_SUB) ? 33'(a_q) - 33'(b_q) : 33'(a_q) + 33'(b_q);
	assign fl  = prod_q[63:16];

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem[rd_addr];
		rd_ok_q <= rd_en;
		if (state_q == ST_DONE && push_q && sp_q != SpW'(StackDepth))
			mem[AddrW'(sp_q)] <= res_q;
		if (state_q == ST_MUL) prod_q <= a_q * b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sp_q      <= '0;
			out_valid <= 1'b0;
			cur_q     <= '0;
			under_q   <= 1'b0; over_q <= 1'b0; sat_q <= 1'b0;
			dz_q      <= 1'b0; pv_q   <= 1'b0; push_q <= 1'b0;
			res_q     <= '0;
			a_q       <= '0; b_q <= '0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (cmd_take) begin
					cur_q   <= cmd;
					under_q <= 1'b0; over_q <= 1'b0; sat_q <= 1'b0;
					dz_q    <= 1'b0; pv_q   <= 1'b0; push_q <= 1'b0;
					res_q   <= cmd.operand;
					a_q     <= '0; b_q <= '0;
					unique case (cmd.op)
						OP_PUSH: begin
							push_q  <= 1'b1;
							state_q <= ST_DONE;
						end
						OP_NONE: state_q <= ST_DONE;
						default: state_q <= ST_RDB;
					endcase
				end
				ST_RDB: begin
					if (sp_q == '0) under_q <= 1'b1;
					else sp_q <= sp_q - 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					b_q <= under_q ? '0 : rd_data_q;
					if (cur_q.op == OP_PRINT) begin
						pv_q    <= 1'b1;
						res_q   <= under_q ? '0 : rd_data_q;
						state_q <= ST_DONE;
					end else if (cur_q.op == OP_DIV && !under_q && rd_data_q == '0) begin
						dz_q    <= 1'b1;
						state_q <= ST_DONE;
					end else if (cur_q.op == OP_DIV && under_q) begin
						dz_q    <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RDA;
					end
				end
				ST_RDA: begin
					if (sp_q == '0) begin
						under_q <= 1'b1;
						a_q     <= '0;
						state_q <= ST_EXEC;
					end else begin
						sp_q    <= sp_q - 1'b1;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// empty-stack pop leaves a at zero
					if (rd_ok_q) a_q <= rd_data_q;
					push_q  <= 1'b1;
					state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (cur_q.op == OP_ADD || cur_q.op == OP_SUB) begin
						if (sum > 33'sd2147483647) begin
							res_q <= QMax; sat_q <= 1'b1;
						end else if (sum < -33'sd2147483648) begin
							res_q <= QMin; sat_q <= 1'b1;
						end else res_q <= sum[31:0];
						state_q <= ST_DONE;
					end else if (cur_q.op == OP_MUL) begin
						if (fl > 48'sh7fffffff) begin
							res_q <= QMax; sat_q <= 1'b1;
						end else if (fl < -48'sh80000000) begin
							res_q <= QMin; sat_q <= 1'b1;
						end else res_q <= fl[31:0];
						state_q <= ST_DONE;
					end else if (div_done) begin
						res_q   <= div_quo;
						sat_q   <= div_sat;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (push_q) begin
						if (sp_q == SpW'(StackDepth)) over_q <= 1'b1;
						else sp_q <= sp_q + 1'b1;
					end
					state_q <= ST_IDLE;
					out_valid <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		out_item.print_valid     = pv_q;
		out_item.printed_value   = pv_q ? res_q : '0;
		out_item.stack_underflow = under_q;
		out_item.stack_overflow  = over_q;
		out_item.divide_by_zero  = dz_q;
		out_item.unknown_command = (cur_q.op == OP_NONE);
		out_item.arith_saturated = sat_q;
		out_item.stack_depth     = 8'(sp_q);
	end
endmodule

// File: rtl/rpn_stack_evaluator_core.sv
// top level of the rpn stack evaluator
// Reverse Polish calculator on signed Q16.16 values with a 128-entry
// operand stack. Each token item gives exactly one status item. The front
// accepts and classifies tokens into a two-deep command queue; the back
// pops operands one memory read at a time, runs the operation and holds
// the result in an output register. A divide runs through the 48-step
// restoring divider that forms the quotient bit by bit. The back takes no
// new command while its result is still held. Stack entries hold no reset
// value and are only read after being written.
module rpn_stack_evaluator_core import rpn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	// front to back command channel
	logic cmd_valid, cmd_take;
	cmd_t cmd;

	rpn_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	rpn_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);
endmodule

// File: tb/testbench.sv
// self-checking testbench for the rpn stack evaluator core
`timescale 1ns / 1ps

module testbench;
	import rpn_pkg::*;

	// clock, reset and handshake signals
	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	// shadow of the core's operand stack
	logic signed [31:0] shadow_stack [StackDepth];
	int unsigned        shadow_depth;

	// expected status items in arrival order, plus failure count
	out_item_t expected_status [$];
	int        mismatch_count;

	// receiver behaviour: long hold-off request, cleared once taken up
	logic rx_hold;
	int   hold_cycles;

	rpn_stack_evaluator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// generous time limit for about 1300 items with random gaps and stalls
	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// predictor: one token in, one status item out, shadow stack updated
	// ---------------------------------------------------------------

	// saturate a wide result to the Q16.16 range
	function automatic logic signed [31:0] q_saturate(input logic signed [63:0] wide,
			inout logic sat);
		if (wide > 64'sh7fffffff) begin
			sat = 1'b1;
			return QMax;
		end
		if (wide < -64'sh80000000) begin
			sat = 1'b1;
			return QMin;
		end
		return wide[31:0];
	endfunction

	function automatic logic signed [31:0] shadow_pop(inout logic under);
		if (shadow_depth == 0) begin
			under = 1'b1;
			return '0;
		end
		shadow_depth--;
		return shadow_stack[shadow_depth];
	endfunction

	function automatic void shadow_push(input logic signed [31:0] v, inout logic over);
		if (shadow_depth < StackDepth) begin
			shadow_stack[shadow_depth] = v;
			shadow_depth++;
		end else begin
			over = 1'b1;
		end
	endfunction

	function automatic out_item_t evaluate_token(input in_item_t tok);
		out_item_t          st;
		logic signed [31:0] lhs, rhs;
		logic signed [63:0] wide;
		logic               under, over, sat;
		under = 1'b0;
		over  = 1'b0;
		sat   = 1'b0;
		st    = '0;
		case (action_t'(tok.action))
			ACT_PUSH: begin
				shadow_push(tok.number_value, over);
			end
			ACT_ADD, ACT_SUB, ACT_MUL: begin
				rhs = shadow_pop(under);
				lhs = shadow_pop(under);
				if (action_t'(tok.action) == ACT_ADD)
					wide = 64'(lhs) + 64'(rhs);
				else if (action_t'(tok.action) == ACT_SUB)
					wide = 64'(lhs) - 64'(rhs);
				else
					wide = (64'(lhs) * 64'(rhs)) >>> 16; // arithmetic shift floors
				shadow_push(q_saturate(wide, sat), over);
			end
			ACT_DIV: begin
				rhs = shadow_pop(under);
				if (rhs != 0) begin
					lhs  = shadow_pop(under);
					// signed division truncates toward zero
					wide = (64'(lhs) * 64'sd65536) / 64'(rhs);
					shadow_push(q_saturate(wide, sat), over);
				end else begin
					// divisor consumed, dividend stays
					st.divide_by_zero = 1'b1;
				end
			end
			ACT_PRINT: begin
				st.printed_value = shadow_pop(under);
				st.print_valid   = 1'b1;
			end
			default: begin
				// unknown and reserved codes leave the stack alone
				st.unknown_command = 1'b1;
			end
		endcase
		st.stack_underflow = under;
		st.stack_overflow  = over;
		st.arith_saturated = sat;
		st.stack_depth     = 8'(shadow_depth);
		return st;
	endfunction

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------

	// offer one token after a random gap, predict it once accepted
	task automatic send_token(input action_t act, input logic signed [31:0] num);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0)
			gap = 0; // back-to-back stretches
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= '{action: act, number_value: num};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_status.push_back(evaluate_token('{action: act, number_value: num}));
	endtask

	// random Q16.16 number, biased to extremes and small values
	function automatic logic signed [31:0] random_number();
		case ($urandom_range(0, 7))
			0:       return QMax;
			1:       return QMin;
			2:       return '0;
			3:       return 32'($urandom_range(0, 8)) <<< 16;
			4:       return -(32'($urandom_range(0, 8)) <<< 16);
			5:       return 32'sd65536 * ($urandom_range(0, 1) ? 1 : -1);
			default: return $urandom();
		endcase
	endfunction

	// ---------------------------------------------------------------
	// receiver side and checking
	// ---------------------------------------------------------------

	// random stall per item, long hold-off when asked
	initial begin
		int wait_cycles;
		out_stall <= 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				rx_hold = 1'b0;
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
			end
			wait_cycles = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0)
				wait_cycles = 0;
			if (wait_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
		mismatch_count++;
	endtask

	// compare every accepted status item with the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_status.size() == 0) begin
				report_mismatch("unexpected item", out_item.stack_depth, '0);
			end else begin
				want = expected_status.pop_front();
				if (out_item.print_valid !== want.print_valid)
					report_mismatch("print_valid", out_item.print_valid, want.print_valid);
				if (out_item.printed_value !== want.printed_value)
					report_mismatch("printed_value", out_item.printed_value,
						want.printed_value);
				if (out_item.stack_underflow !== want.stack_underflow)
					report_mismatch("stack_underflow", out_item.stack_underflow,
						want.stack_underflow);
				if (out_item.stack_overflow !== want.stack_overflow)
					report_mismatch("stack_overflow", out_item.stack_overflow,
						want.stack_overflow);
				if (out_item.divide_by_zero !== want.divide_by_zero)
					report_mismatch("divide_by_zero", out_item.divide_by_zero,
						want.divide_by_zero);
				if (out_item.unknown_command !== want.unknown_command)
					report_mismatch("unknown_command", out_item.unknown_command,
						want.unknown_command);
				if (out_item.arith_saturated !== want.arith_saturated)
					report_mismatch("arith_saturated", out_item.arith_saturated,
						want.arith_saturated);
				if (out_item.stack_depth !== want.stack_depth)
					report_mismatch("stack_depth", out_item.stack_depth, want.stack_depth);
			end
		end
	end

	// ---------------------------------------------------------------
	// test tasks
	// ---------------------------------------------------------------

	// every operation on an empty stack: underflow paths, print of nothing
	task automatic test_empty_stack();
		send_token(ACT_ADD, '0);
		send_token(ACT_PRINT, '0);
		send_token(ACT_SUB, '0);
		send_token(ACT_PRINT, '0);
		send_token(ACT_MUL, '0);
		send_token(ACT_PRINT, '0);
		send_token(ACT_DIV, '0); // zero divisor and underflow together
		send_token(ACT_PRINT, '0);
		send_token(ACT_UNK, 32'shffffffff);
		send_token(ACT_RSVD, 32'sh12345678);
	endtask

	// saturation at both ends, floor on multiply, zero divisor with dividend kept
	task automatic test_arith_extremes();
		send_token(ACT_PUSH, QMax);
		send_token(ACT_PUSH, QMax);
		send_token(ACT_ADD, '0);
		send_token(ACT_PUSH, QMin);
		send_token(ACT_SUB, '0);
		send_token(ACT_PUSH, QMin);
		send_token(ACT_MUL, '0);
		send_token(ACT_PUSH, 32'sh00000001);
		send_token(ACT_DIV, '0);
		send_token(ACT_PUSH, 32'shffffffff);
		send_token(ACT_MUL, '0);
		send_token(ACT_PUSH, '0);
		send_token(ACT_DIV, '0);
		send_token(ACT_PRINT, '0);
		send_token(ACT_PRINT, '0);
	endtask

	// fill to the top, overflow pushes, then drain past empty
	task automatic test_full_stack();
		for (int i = 0; i < StackDepth + 3; i++)
			send_token(ACT_PUSH, $urandom());
		send_token(ACT_ADD, '0);
		send_token(ACT_PUSH, QMin);
		send_token(ACT_PUSH, QMax);
		for (int i = 0; i < StackDepth + 2; i++)
			send_token(ACT_PRINT, '0);
	endtask

	// long receiver hold-off while tokens keep coming, so the core backs up
	task automatic test_back_pressure();
		hold_cycles = 300;
		rx_hold     = 1'b1;
		for (int i = 0; i < 20; i++)
			send_token(action_t'($urandom_range(0, 5)), random_number());
	endtask

	// mostly well-formed expressions with random content, some noise
	task automatic test_random_tokens(input int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) < 7) begin
				// two operands, an operator, sometimes print the result
				send_token(ACT_PUSH, random_number());
				send_token(ACT_PUSH, random_number());
				send_token(action_t'($urandom_range(1, 4)), random_number());
				sent += 3;
				if ($urandom_range(0, 1)) begin
					send_token(ACT_PRINT, random_number());
					sent++;
				end
			end else begin
				send_token(action_t'($urandom_range(0, 7)), $urandom());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_item        = '0;
		rx_hold        = 1'b0;
		hold_cycles    = 0;
		mismatch_count = 0;
		shadow_depth   = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_stack();
		test_arith_extremes();
		test_full_stack();
		test_back_pressure();
		test_random_tokens(1000);
		in_valid <= 1'b0;

		// wait for outstanding status items, then let the core settle
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (mismatch_count == 0 && expected_status.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
